FILE: rtl/gpi_pkg.sv
package gpi_pkg;

  localparam int WORD_W              = 32;
  localparam int HALF_W              = WORD_W / 2;
  localparam int PIN_COUNT_DEF       = 32;
  localparam bit HAS_EDGE_SELECT_DEF = 1'b1;

  // stream widths
  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = 5;
  localparam int OUT_TDATA_W = 104;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    REG_DATA     = 3'd0,
    REG_DIR      = 3'd1,
    REG_PAD      = 3'd2,
    REG_CTL_LOW  = 3'd3,
    REG_CTL_HIGH = 3'd4,
    REG_MASK     = 3'd5,
    REG_STATUS   = 3'd6,
    REG_EDGE_SEL = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    TRIG_LOW_LEVEL  = 2'd0,
    TRIG_HIGH_LEVEL = 2'd1,
    TRIG_RISING     = 2'd2,
    TRIG_FALLING    = 2'd3
  } trig_t;

  // what one pin lane looks at
  typedef struct packed {
    trig_t code;
    logic  both_edge;
    logic  cur;
    logic  old;
  } lane_in_t;

  // one result; first member lands in the top bits
  typedef struct packed {
    logic [WORD_W-1:0] pad_output_enable;
    logic [WORD_W-1:0] pad_drive;
    logic              irq_high_half;
    logic              irq_low_half;
    logic [WORD_W-1:0] read_data;
  } res_t;

  localparam int RES_W = $bits(res_t);

endpackage

FILE: rtl/gpio_port_interrupt_block.sv
// channel | dir | tdata (low bit up)                              | tuser
// in_     | in  | write_data[31:0], pin_levels[63:32]             | operation[1:0], reg_index[4:2]
// out_    | out | read_data[31:0], irq_low_half[32],              | -
//         |     | irq_high_half[33], pad_drive[65:34],            |
//         |     | pad_output_enable[97:66], zero[103:98]          |
//
// One transaction per clock while in_tready is high: register access and pin sampling
// finish in the cycle the item is taken, one lane per pin; the result sits in a two-entry
// output stage. in_tready drops only when both output entries hold unread results.
// Synchronous active-low reset clears all registers and empties the output stage.
module gpio_port_interrupt_block #(
  parameter int PIN_COUNT       = gpi_pkg::PIN_COUNT_DEF,
  parameter bit HAS_EDGE_SELECT = gpi_pkg::HAS_EDGE_SELECT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // write_data[31:0], pin_levels[63:32]
  input  logic [gpi_pkg::IN_TDATA_W-1:0]  in_tdata,
  // operation[1:0], reg_index[4:2]
  input  logic [gpi_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // read_data[31:0], irq_low_half[32], irq_high_half[33], pad_drive[65:34],
  // pad_output_enable[97:66], zero[103:98]
  output logic [gpi_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import gpi_pkg::*;

  localparam logic [WORD_W-1:0] PIN_MASK = WORD_W'((64'd1 << PIN_COUNT) - 64'd1);

  logic [WORD_W-1:0] data_r, data_nxt;
  logic [WORD_W-1:0] dir_r, dir_nxt;
  logic [WORD_W-1:0] pad_r, pad_nxt;
  logic [WORD_W-1:0] ctl_low_r, ctl_low_nxt;
  logic [WORD_W-1:0] ctl_high_r, ctl_high_nxt;
  logic [WORD_W-1:0] mask_r, mask_nxt;
  logic [WORD_W-1:0] status_r, status_nxt;
  logic [WORD_W-1:0] edge_sel_r, edge_sel_nxt;

  op_t               op;
  reg_idx_t          reg_idx;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] pins;
  logic [WORD_W-1:0] fire;
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] pending;
  logic              accept;
  logic              can_push;
  res_t              res;
  res_t              out_res;

  assign op      = op_t'(in_tuser[1:0]);
  assign reg_idx = reg_idx_t'(in_tuser[4:2]);
  assign wdata   = in_tdata[WORD_W-1:0];
  assign pins    = in_tdata[2*WORD_W-1:WORD_W] & PIN_MASK;
  assign accept  = in_tvalid & in_tready;
  assign in_tready = can_push;

  // one lane per present pin
  for (genvar i = 0; i < WORD_W; i++) begin : g_lane
    if (i < PIN_COUNT) begin : g_pin
      localparam int SH = (i % HALF_W) * 2;
      lane_in_t lane_in;
      assign lane_in.code      = (i < HALF_W) ? trig_t'(ctl_low_r[SH +: 2])
                                              : trig_t'(ctl_high_r[SH +: 2]);
      assign lane_in.both_edge = edge_sel_r[i];
      assign lane_in.cur       = pins[i];
      assign lane_in.old       = pad_r[i];
      gpi_pin_lane u_lane (
        .lane_in (lane_in),
        .hit     (fire[i])
      );
    end else begin : g_absent
      assign fire[i] = 1'b0;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DATA:     rdata = data_r;
      REG_DIR:      rdata = dir_r;
      REG_PAD:      rdata = pad_r;
      REG_CTL_LOW:  rdata = ctl_low_r;
      REG_CTL_HIGH: rdata = ctl_high_r;
      REG_MASK:     rdata = mask_r;
      REG_STATUS:   rdata = status_r;
      REG_EDGE_SEL: rdata = edge_sel_r;
      default:      rdata = '0;
    endcase
  end

  always_comb begin
    data_nxt     = data_r;
    dir_nxt      = dir_r;
    pad_nxt      = pad_r;
    ctl_low_nxt  = ctl_low_r;
    ctl_high_nxt = ctl_high_r;
    mask_nxt     = mask_r;
    status_nxt   = status_r;
    edge_sel_nxt = edge_sel_r;
    unique case (op)
      OP_WRITE: begin
        unique case (reg_idx)
          REG_DATA:     data_nxt     = wdata & PIN_MASK;
          REG_DIR:      dir_nxt      = wdata & PIN_MASK;
          REG_CTL_LOW:  ctl_low_nxt  = wdata;
          REG_CTL_HIGH: ctl_high_nxt = wdata;
          REG_MASK:     mask_nxt     = wdata & PIN_MASK;
          REG_STATUS:   status_nxt   = status_r & ~wdata;
          REG_EDGE_SEL: edge_sel_nxt = HAS_EDGE_SELECT ? (wdata & PIN_MASK) : edge_sel_r;
          default:      ; // pad status is read only
        endcase
      end
      OP_TICK: begin
        status_nxt = (status_r | fire) & PIN_MASK;
        pad_nxt    = pins;
      end
      default: ; // reads and the unused code change nothing
    endcase
  end

  assign pending = status_nxt & mask_nxt;

  always_comb begin
    res.read_data         = (op == OP_READ) ? rdata : '0;
    res.irq_low_half      = |pending[HALF_W-1:0];
    res.irq_high_half     = |pending[WORD_W-1:HALF_W];
    res.pad_drive         = data_nxt;
    res.pad_output_enable = dir_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r     <= '0;
      dir_r      <= '0;
      pad_r      <= '0;
      ctl_low_r  <= '0;
      ctl_high_r <= '0;
      mask_r     <= '0;
      status_r   <= '0;
      edge_sel_r <= '0;
    end else if (accept) begin
      data_r     <= data_nxt;
      dir_r      <= dir_nxt;
      pad_r      <= pad_nxt;
      ctl_low_r  <= ctl_low_nxt;
      ctl_high_r <= ctl_high_nxt;
      mask_r     <= mask_nxt;
      status_r   <= status_nxt;
      edge_sel_r <= edge_sel_nxt;
    end
  end

  gpi_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {(OUT_TDATA_W - RES_W)'(0), out_res};

endmodule

FILE: rtl/gpi_pin_lane.sv
module gpi_pin_lane (
  input  gpi_pkg::lane_in_t lane_in,
  output logic              hit
);
  import gpi_pkg::*;

  always_comb begin
    if (lane_in.both_edge) begin
      hit = lane_in.cur ^ lane_in.old;
    end else begin
      case (lane_in.code)
        TRIG_LOW_LEVEL:  hit = ~lane_in.cur;
        TRIG_HIGH_LEVEL: hit = lane_in.cur;
        TRIG_RISING:     hit = lane_in.cur & ~lane_in.old;
        TRIG_FALLING:    hit = lane_in.old & ~lane_in.cur;
        default:         hit = 1'b0;
      endcase
    end
  end

endmodule

FILE: rtl/gpi_out_skid.sv
module gpi_out_skid (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gpi_pkg::res_t push_data,
  output logic          can_push,
  output logic          out_valid,
  input  logic          out_ready,
  output gpi_pkg::res_t out_data
);
  import gpi_pkg::*;

  logic main_valid_r, main_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t main_data_r, main_data_nxt;
  res_t skid_data_r, skid_data_nxt;
  logic pop;

  assign can_push  = ~skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;
  assign pop       = main_valid_r & out_ready;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_data_nxt  = main_data_r;
    skid_data_nxt  = skid_data_r;
    // push is never high while the skid slot is full
    if (skid_valid_r) begin
      if (pop) begin
        main_data_nxt  = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_data_nxt  = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_data_r <= main_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule
